// File: rtl/sdr_pkg.sv
// ----------------------------------------------------------------------------
// sdr_pkg
// Shared types and constants for the marine-bus datagram receiver.
// ----------------------------------------------------------------------------
package sdr_pkg;

   localparam int BUFFER_LIMIT_DEFAULT = 18;
   localparam int QUEUE_DEPTH          = 2;

   localparam int INDEX_W  = 5;
   localparam int LENGTH_W = 5;
   localparam int WIND_W   = 11;
   localparam int MODE_W   = 2;

   // Datagram length is this much more than the low nibble of byte 1.
   localparam logic [LENGTH_W-1:0] LENGTH_BASE = 5'd3;

   // Command codes
   localparam logic [7:0] CMD_WIND      = 8'h11;
   localparam logic [7:0] CMD_AUTOPILOT = 8'h84;

   // Autopilot status byte 2 codes
   localparam logic [7:0] AP_CODE_STANDBY = 8'h00;
   localparam logic [7:0] AP_CODE_AUTO    = 8'h40;

   // Autopilot mode encoding
   localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd0;
   localparam logic [MODE_W-1:0] MODE_STANDBY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_AUTO    = 2'd2;

   localparam logic [WIND_W-1:0] WIND_SCALE = 11'd10;
   localparam logic [WIND_W-1:0] WIND_MAX   = 11'd1525;

   localparam logic [LENGTH_W-1:0] LENGTH_MIN = 5'd3;
   localparam logic [LENGTH_W-1:0] LENGTH_MAX = 5'd18;

   // One completed datagram, as handed from the front end to the back end.
   typedef struct packed {
      logic [7:0]          command_byte;
      logic [LENGTH_W-1:0] length;
      logic [7:0]          byte2;
      logic [7:0]          byte3;
   } dgram_type;

endpackage

// File: rtl/sdr_front.sv
// ----------------------------------------------------------------------------
// sdr_front
// Character front end: tracks byte index, captures the first four bytes and
// emits one datagram record when the datagram length is reached.
// ----------------------------------------------------------------------------
module sdr_front
   import sdr_pkg::*;
#(
   parameter int BUFFER_LIMIT = BUFFER_LIMIT_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      receive_enable,
   input  logic      char_accept,
   input  logic      command_bit,
   input  logic [7:0] data_byte,
   output logic      push,
   output dgram_type push_data
);

   logic [INDEX_W-1:0]  idx_ff, idx_in;
   logic [7:0]          cap_ff [4];
   logic [7:0]          cap_in [4];
   logic [INDEX_W-1:0]  idx_start;
   logic [INDEX_W-1:0]  idx_next;
   logic [LENGTH_W-1:0] dg_length;
   logic                take;

   always_comb begin
      idx_start = command_bit ? '0 : idx_ff;
      take      = char_accept && receive_enable &&
                  ({1'b0, idx_start} < (INDEX_W+1)'(BUFFER_LIMIT));
      idx_next  = idx_start + INDEX_W'(1);
      dg_length = LENGTH_W'(cap_ff[1][3:0]) + LENGTH_BASE;

      idx_in = idx_ff;
      for (int i = 0; i < 4; i++) begin
         cap_in[i] = cap_ff[i];
      end
      push = 1'b0;

      if (take) begin
         if (idx_start < INDEX_W'(4)) begin
            cap_in[idx_start[1:0]] = data_byte;
         end
         // byte 1 is never written in the step that completes a datagram
         if (idx_next >= INDEX_W'(3) && idx_next == INDEX_W'(dg_length)) begin
            push   = 1'b1;
            idx_in = '0;
         end else begin
            idx_in = idx_next;
         end
      end

      push_data.command_byte = cap_in[0];
      push_data.length       = dg_length;
      push_data.byte2        = cap_in[2];
      push_data.byte3        = cap_in[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            cap_ff[i] <= '0;
         end
      end else begin
         idx_ff <= idx_in;
         for (int i = 0; i < 4; i++) begin
            cap_ff[i] <= cap_in[i];
         end
      end
   end

endmodule

// File: rtl/sdr_queue.sv
// ----------------------------------------------------------------------------
// sdr_queue
// Small register FIFO of datagram records between front and back end.
// ----------------------------------------------------------------------------
module sdr_queue
   import sdr_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  dgram_type push_data,
   input  logic      pop,
   output dgram_type pop_data,
   output logic      full,
   output logic      not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dgram_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/sdr_back.sv
// ----------------------------------------------------------------------------
// sdr_back
// Datagram back end: decodes wind and autopilot commands, holds their
// values and drives the registered result transaction.
// ----------------------------------------------------------------------------
module sdr_back
   import sdr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                rec_valid,
   input  dgram_type           rec_data,
   output logic                rec_pop,
   output logic                out_valid,
   input  logic                out_stall,
   output logic [7:0]          out_command_byte,
   output logic [LENGTH_W-1:0] out_length,
   output logic [WIND_W-1:0]   out_wind,
   output logic [MODE_W-1:0]   out_mode,
   output logic                out_wind_updated,
   output logic                out_mode_updated
);

   logic [WIND_W-1:0]   wind_ff, wind_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic                valid_ff, valid_in;
   logic [7:0]          cmd_ff;
   logic [LENGTH_W-1:0] len_ff;
   logic [WIND_W-1:0]   owind_ff;
   logic [MODE_W-1:0]   omode_ff;
   logic                wupd_ff, wupd_in;
   logic                mupd_ff, mupd_in;

   assign rec_pop = rec_valid && (!valid_ff || !out_stall);

   always_comb begin
      wind_in  = wind_ff;
      mode_in  = mode_ff;
      wupd_in  = 1'b0;
      mupd_in  = 1'b0;
      valid_in = valid_ff && out_stall;
      if (rec_pop) begin
         valid_in = 1'b1;
         case (rec_data.command_byte)
            CMD_WIND: begin
               wind_in = WIND_W'(rec_data.byte2[6:0]) * WIND_SCALE
                         + WIND_W'(rec_data.byte3);
               wupd_in = 1'b1;
            end
            CMD_AUTOPILOT: begin
               if (rec_data.byte2 == AP_CODE_STANDBY) begin
                  mode_in = MODE_STANDBY;
               end else if (rec_data.byte2 == AP_CODE_AUTO) begin
                  mode_in = MODE_AUTO;
               end
               mupd_in = (mode_in != mode_ff);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wind_ff  <= '0;
         mode_ff  <= MODE_UNKNOWN;
         valid_ff <= 1'b0;
      end else begin
         wind_ff  <= wind_in;
         mode_ff  <= mode_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_pop) begin
         cmd_ff   <= rec_data.command_byte;
         len_ff   <= rec_data.length;
         owind_ff <= wind_in;
         omode_ff <= mode_in;
         wupd_ff  <= wupd_in;
         mupd_ff  <= mupd_in;
      end
   end

   assign out_valid        = valid_ff;
   assign out_command_byte = cmd_ff;
   assign out_length       = len_ff;
   assign out_wind         = owind_ff;
   assign out_mode         = omode_ff;
   assign out_wind_updated = wupd_ff;
   assign out_mode_updated = mupd_ff;

endmodule

// File: rtl/seatalk_datagram_receiver.sv
// ----------------------------------------------------------------------------
// seatalk_datagram_receiver
// The queue is written at the edge that takes the final character; the back end output register
// takes the record from the queue once that register is empty or its result is not stalled.
// Throughput: one character per cycle unless stalled; a result per cycle while rsp_stall is low.
// The input stalls only while the two-entry datagram queue is full.
// Synchronous active-high reset clears index, captured bytes, wind speed,
// autopilot mode (unknown) and receive enable; no clearing pass is needed.
// ----------------------------------------------------------------------------
module seatalk_datagram_receiver
   import sdr_pkg::*;
#(
   parameter int BUFFER_LIMIT = BUFFER_LIMIT_DEFAULT,
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_write_enable,
   input  logic                csr_write_data,
   // character transactions
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_command_bit,
   input  logic [7:0]          req_data_byte,
   // datagram result transactions
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_command_byte,
   output logic [LENGTH_W-1:0] rsp_datagram_length,
   output logic [WIND_W-1:0]   rsp_wind_speed_tenths,
   output logic [MODE_W-1:0]   rsp_autopilot_mode,
   output logic                rsp_wind_updated,
   output logic                rsp_mode_updated
);

   // Receive enable register; the user must write it only while the block is idle (not enforced here).
   logic      enable_ff;

   logic      char_accept;
   logic      push;
   dgram_type push_data;
   logic      pop;
   dgram_type pop_data;
   logic      queue_full;
   logic      queue_not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else if (csr_write_enable) begin
         enable_ff <= csr_write_data;
      end
   end

   // A character is only held back when a completed datagram could have
   // nowhere to go; disabled characters are accepted and dropped.
   assign req_stall   = queue_full;
   assign char_accept = req_valid && !req_stall;

   // Front end: index tracking and byte capture, one character per cycle while the queue is not full.
   sdr_front #(
      .BUFFER_LIMIT (BUFFER_LIMIT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .receive_enable (enable_ff),
      .char_accept    (char_accept),
      .command_bit    (req_command_bit),
      .data_byte      (req_data_byte),
      .push           (push),
      .push_data      (push_data)
   );

   // Decoupling queue of completed datagrams.
   sdr_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .not_empty (queue_not_empty)
   );

   // Back end: command decode, held wind/mode state and output register.
   sdr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .rec_valid        (queue_not_empty),
      .rec_data         (pop_data),
      .rec_pop          (pop),
      .out_valid        (rsp_valid),
      .out_stall        (rsp_stall),
      .out_command_byte (rsp_command_byte),
      .out_length       (rsp_datagram_length),
      .out_wind         (rsp_wind_speed_tenths),
      .out_mode         (rsp_autopilot_mode),
      .out_wind_updated (rsp_wind_updated),
      .out_mode_updated (rsp_mode_updated)
   );

endmodule

// File: rtl/sdr_checker.sv
// ----------------------------------------------------------------------------
// sdr_checker
// Port-level checks on the datagram receiver, bound to the top level.
// ----------------------------------------------------------------------------
module sdr_checker
   import sdr_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [7:0]          rsp_command_byte,
   input logic [LENGTH_W-1:0] rsp_datagram_length,
   input logic [WIND_W-1:0]   rsp_wind_speed_tenths,
   input logic [MODE_W-1:0]   rsp_autopilot_mode,
   input logic                rsp_wind_updated,
   input logic                rsp_mode_updated
);

   // A held result transaction keeps its command byte, length and wind speed.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_command_byte)
         && $stable(rsp_datagram_length) && $stable(rsp_wind_speed_tenths))
      else $error("result changed while stalled");

   a_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_datagram_length >= LENGTH_MIN
         && rsp_datagram_length <= LENGTH_MAX
         && rsp_wind_speed_tenths <= WIND_MAX)
      else $error("result length or wind speed out of range");

   a_wind_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_wind_updated == (rsp_command_byte == CMD_WIND))
      else $error("wind flag does not match command");

   a_mode_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode_updated |-> rsp_command_byte == CMD_AUTOPILOT
         && (rsp_autopilot_mode == MODE_STANDBY || rsp_autopilot_mode == MODE_AUTO))
      else $error("mode update without valid autopilot datagram");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

endmodule

bind seatalk_datagram_receiver sdr_checker u_sdr_checker (.*);
